>>> rtl/lrupr_pkg.sv
// Shared constants for the LRU page replacement block.
// No dependencies.
package lrupr_pkg;

    localparam int DEF_FRAMES    = 4;
    localparam int DEF_PAGE_BITS = 16;

    // Fixed port widths
    localparam int PAGE_W = 16;
    localparam int SLOT_W = 2;
    localparam int FILL_W = 3;
    localparam int CNT_W  = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

>>> rtl/lru_page_replacement.sv
// LRU page replacement over FRAMES fully associative frames; uses lrupr_pkg.
// o_valid is registered out of ST_UPDATE, after the scan has passed over all FRAMES frames.
// A new reference is taken only in ST_IDLE (busy low), after the last one is through: the accepting cycle,
// one ST_SCAN step per frame with one tag compare each, then ST_UPDATE for the hit, fill or eviction.
// Results come out as a one-cycle strobe; the receiver cannot stall.
// Reset (synchronous, active low) empties all frames and zeroes the fault count.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = DEF_FRAMES,
    parameter int PAGE_BITS = DEF_PAGE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [PAGE_W-1:0] i_page_number,
    input  logic              i_is_last,
    output logic              o_valid,
    output logic              o_hit,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_evicted_valid,
    output logic [PAGE_W-1:0] o_evicted_page,
    output logic [FILL_W-1:0] o_frames_filled,
    output logic [CNT_W-1:0]  o_fault_total
);

    localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RW = IW;
    localparam int FW = $clog2(FRAMES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    t_state              r_state;
    logic [PW-1:0]       r_pages [FRAMES];
    logic [FRAMES-1:0]   r_valid;
    logic [RW-1:0]       r_rank  [FRAMES];
    logic [CNT_W-1:0]    r_faults;

    // per-reference working registers
    logic [PW-1:0]       r_page;
    logic                r_last;
    logic [IW-1:0]       r_idx;
    logic [FW-1:0]       r_filled;
    logic                r_hit_found;
    logic [IW-1:0]       r_hit_idx;
    logic [RW-1:0]       r_hit_rank;
    logic                r_empty_found;
    logic [IW-1:0]       r_empty_idx;
    logic [IW-1:0]       r_vic_idx;
    logic [RW-1:0]       r_vic_rank;
    logic [PW-1:0]       r_vic_page;

    // shared compare on the frame under the scan pointer
    logic                cur_valid;
    logic                cur_match;
    logic                cur_older;

    logic                upd_fill;
    logic [IW-1:0]       f_sel;
    logic [FW-1:0]       n_filled;
    logic [CNT_W-1:0]    n_faults;

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        cur_valid = r_valid[r_idx];
        cur_match = cur_valid && (r_pages[r_idx] == r_page);
        cur_older = (r_idx == '0) || (r_rank[r_idx] > r_vic_rank);

        upd_fill = !r_hit_found && r_empty_found;
        if (r_hit_found) begin
            f_sel = r_hit_idx;
        end else if (r_empty_found) begin
            f_sel = r_empty_idx;
        end else begin
            f_sel = r_vic_idx;
        end
        n_filled = r_filled + FW'(upd_fill);
        if (!r_hit_found && (r_faults != CNT_MAX)) begin
            n_faults = r_faults + CNT_W'(1);
        end else begin
            n_faults = r_faults;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_faults <= '0;
            o_valid  <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_page        <= i_page_number[PW-1:0];
                        r_last        <= i_is_last;
                        r_idx         <= '0;
                        r_filled      <= '0;
                        r_hit_found   <= 1'b0;
                        r_empty_found <= 1'b0;
                        r_state       <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cur_valid) begin
                        r_filled <= r_filled + FW'(1);
                        if (cur_match && !r_hit_found) begin
                            r_hit_found <= 1'b1;
                            r_hit_idx   <= r_idx;
                            r_hit_rank  <= r_rank[r_idx];
                        end
                    end else if (!r_empty_found) begin
                        r_empty_found <= 1'b1;
                        r_empty_idx   <= r_idx;
                    end
                    // victim: highest rank, lowest index on ties
                    if (cur_older) begin
                        r_vic_idx  <= r_idx;
                        r_vic_rank <= r_rank[r_idx];
                        r_vic_page <= r_pages[r_idx];
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= ST_UPDATE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                ST_UPDATE: begin
                    o_valid         <= 1'b1;
                    o_hit           <= r_hit_found;
                    o_slot          <= SLOT_W'(f_sel);
                    o_evicted_valid <= !r_hit_found && !r_empty_found;
                    o_evicted_page  <= (!r_hit_found && !r_empty_found)
                                       ? PAGE_W'(r_vic_page) : '0;
                    o_frames_filled <= FILL_W'(n_filled);
                    o_fault_total   <= n_faults;
                    r_state         <= ST_IDLE;

                    if (r_last) begin
                        r_valid  <= '0;
                        r_faults <= '0;
                        for (int i = 0; i < FRAMES; i++) begin
                            r_rank[i] <= '0;
                        end
                    end else begin
                        r_faults <= n_faults;
                        if (!r_hit_found) begin
                            r_pages[f_sel] <= r_page;
                            r_valid[f_sel] <= 1'b1;
                        end
                        // age the frames that were newer than the touched one (every valid frame on a miss)
                        for (int i = 0; i < FRAMES; i++) begin
                            if (IW'(i) == f_sel) begin
                                r_rank[i] <= '0;
                            end else if (r_valid[i] &&
                                         (!r_hit_found || (r_rank[i] < r_hit_rank))) begin
                                r_rank[i] <= r_rank[i] + RW'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
